@@ rtl/unordered_set_table_defines.svh @@
// Assertion macros used by the top-level module to check its own behavior.
`ifndef UNORDERED_SET_TABLE_DEFINES_SVH
`define UNORDERED_SET_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UST_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define UST_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/ust_pkg.sv @@
`timescale 1ns / 1ps

package ust_pkg;

    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic signed [VALUE_W-1:0] item_value;
    } in_item_t;

    typedef struct packed {
        logic                found;
        logic [POS_W-1:0]    position;
        logic [POS_W-1:0]    entry_count;
        logic [STATUS_W-1:0] status;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic search;
        logic latch_status;
        logic wr_insert;
        logic rd_last;
        logic wr_move;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic search_done;
        logic do_insert;
        logic do_move;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/unordered_set_table.sv @@
`timescale 1ns / 1ps
// Set of distinct signed 32-bit values kept in an unordered single-port-read RAM.
// Input channel s_valid/s_ready/s_data carries one operation per transaction:
// query, insert or delete of item_value (action code 3 acts as a query).
// Result channel m_valid/m_ready/m_data returns exactly one transaction per
// operation: found flag, slot position, entry count after the operation, status.
// Each operation scans the used slots one per cycle through the RAM read port,
// stopping at a match; then an insert that adds the value writes it to the
// next free slot, and a delete that hits reads the last entry and moves it
// into the freed slot; then the result is registered. One operation is in
// flight at a time; the next can be accepted once the previous result is
// registered.
// Synchronous active-low reset empties the set and drops any pending result;
// the RAM contents are not cleared since only slots below the count are read.
// When the receiver stalls, the result holds in the output register and the
// block can still accept and process one more operation, which then waits to
// be registered until the output register is free.
`include "unordered_set_table_defines.svh"

module unordered_set_table #(
    parameter int CAPACITY = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ust_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ust_pkg::out_item_t m_data
);

    ust_pkg::cmd_t cmd;
    ust_pkg::sts_t sts;

    ust_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    ust_dp #(
        .CAPACITY(CAPACITY)
    ) u_dp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_data (s_data),
        .cmd    (cmd),
        .sts    (sts),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    `UST_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)
    `UST_ASSERT_NOW(a_no_overwrite, aclk, aresetn, cmd.load_out, sts.out_free)
    `UST_ASSERT_NOW(a_full_not_found, aclk, aresetn,
        m_valid && (m_data.status == ust_pkg::ST_FULL), !m_data.found)
    `UST_ASSERT_NOW(a_absent_not_found, aclk, aresetn,
        m_valid && (m_data.status == ust_pkg::ST_ABSENT), !m_data.found)

endmodule

@@ rtl/ust_ram.sv @@
`timescale 1ns / 1ps

module ust_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/ust_ctrl.sv @@
`timescale 1ns / 1ps

module ust_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ust_pkg::sts_t sts,
    output ust_pkg::cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SEARCH   = 6'b000010,
        S_WRITE    = 6'b000100,
        S_READLAST = 6'b001000,
        S_MOVE     = 6'b010000,
        S_RESULT   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready   = 1'b1;
                cmd.start = s_valid;
                if (s_valid) begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH: begin
                cmd.search = 1'b1;
                if (sts.search_done) begin
                    cmd.latch_status = 1'b1;
                    if (sts.do_insert) begin
                        state_next = S_WRITE;
                    end else if (sts.do_move) begin
                        state_next = S_READLAST;
                    end else begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_WRITE: begin
                cmd.wr_insert = 1'b1;
                state_next    = S_RESULT;
            end
            S_READLAST: begin
                cmd.rd_last = 1'b1;
                state_next  = S_MOVE;
            end
            S_MOVE: begin
                cmd.wr_move = 1'b1;
                state_next  = S_RESULT;
            end
            S_RESULT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/ust_dp.sv @@
`timescale 1ns / 1ps

module ust_dp #(
    parameter int CAPACITY = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ust_pkg::in_item_t  s_data,
    input  ust_pkg::cmd_t      cmd,
    output ust_pkg::sts_t      sts,
    output logic               m_valid,
    input  logic               m_ready,
    output ust_pkg::out_item_t m_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int EXT_W = CNT_W + ust_pkg::POS_W;

    logic [ust_pkg::ACTION_W-1:0] act_reg;
    logic [ust_pkg::VALUE_W-1:0]  value_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             rd_idx_reg;
    logic [CNT_W-1:0]             cmp_idx_reg;
    logic                         pend_reg;
    logic                         hit_reg;
    logic [CNT_W-1:0]             pos_reg;
    logic [ust_pkg::STATUS_W-1:0] status_reg;
    ust_pkg::out_item_t           out_reg;
    logic                         m_valid_reg;

    logic                         issue;
    logic                         match;
    logic                         full;
    logic [ust_pkg::STATUS_W-1:0] status_next;
    logic [CNT_W-1:0]             last_idx;
    logic                         we;
    logic [AW-1:0]                waddr;
    logic [AW-1:0]                raddr;
    logic [ust_pkg::VALUE_W-1:0]  wdata;
    logic [ust_pkg::VALUE_W-1:0]  rdata;
    logic [EXT_W-1:0]             pos_ext;
    logic [EXT_W-1:0]             count_ext;

    ust_ram #(
        .WIDTH(ust_pkg::VALUE_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign issue    = cmd.search && (rd_idx_reg < count_reg) && !hit_reg;
    assign match    = cmd.search && pend_reg && !hit_reg && (rdata == value_reg);
    assign last_idx = count_reg - CNT_W'(1);

    assign raddr = cmd.rd_last ? last_idx[AW-1:0] : rd_idx_reg[AW-1:0];
    assign we    = cmd.wr_insert || cmd.wr_move;
    assign waddr = cmd.wr_insert ? count_reg[AW-1:0] : pos_reg[AW-1:0];
    assign wdata = cmd.wr_insert ? value_reg : rdata;

    always_comb begin
        status_next = ust_pkg::ST_DONE;
        case (act_reg)
            ust_pkg::ACT_INSERT: begin
                if (hit_reg) begin
                    status_next = ust_pkg::ST_PRESENT;
                end else if (full) begin
                    status_next = ust_pkg::ST_FULL;
                end
            end
            ust_pkg::ACT_DELETE: begin
                if (!hit_reg) begin
                    status_next = ust_pkg::ST_ABSENT;
                end
            end
            default: begin
                status_next = ust_pkg::ST_DONE;
            end
        endcase
    end

    assign sts.search_done = hit_reg || ((rd_idx_reg == count_reg) && !pend_reg);
    assign sts.do_insert   = (act_reg == ust_pkg::ACT_INSERT) && !hit_reg && !full;
    assign sts.do_move     = (act_reg == ust_pkg::ACT_DELETE) && hit_reg;
    assign sts.out_free    = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.wr_insert) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (cmd.wr_move) begin
                count_reg <= last_idx;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            act_reg    <= s_data.action;
            value_reg  <= s_data.item_value;
            rd_idx_reg <= '0;
            pend_reg   <= 1'b0;
            hit_reg    <= 1'b0;
            pos_reg    <= count_reg;
        end else if (cmd.search) begin
            pend_reg    <= issue;
            cmp_idx_reg <= rd_idx_reg;
            if (issue) begin
                rd_idx_reg <= rd_idx_reg + CNT_W'(1);
            end
            if (match) begin
                hit_reg <= 1'b1;
                pos_reg <= cmp_idx_reg;
            end
        end
        if (cmd.latch_status) begin
            status_reg <= status_next;
        end
        if (cmd.load_out) begin
            out_reg.found       <= hit_reg;
            out_reg.position    <= pos_ext[ust_pkg::POS_W-1:0];
            out_reg.entry_count <= count_ext[ust_pkg::POS_W-1:0];
            out_reg.status      <= status_reg;
        end
    end

    assign pos_ext   = {{ust_pkg::POS_W{1'b0}}, pos_reg};
    assign count_ext = {{ust_pkg::POS_W{1'b0}}, count_reg};

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

@@ dv/unordered_set_table_test.sv @@
`timescale 1ns / 1ps

module unordered_set_table_test;

    localparam int CAPACITY = 64;
    localparam logic [ust_pkg::ACTION_W-1:0] ACT_SPARE = 2'd3;
    localparam logic signed [ust_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [ust_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ust_pkg::VALUE_W-1:0] VAL_ZERO = 32'sd0;
    localparam logic signed [ust_pkg::VALUE_W-1:0] VAL_NEG1 = -32'sd1;
    localparam logic signed [ust_pkg::VALUE_W-1:0] VAL_ALT0 = 32'sh5555_5555;
    localparam logic signed [ust_pkg::VALUE_W-1:0] VAL_ALT1 = 32'shAAAA_AAAA;
    localparam int RANDOM_OPS = 1650;
    localparam int PHASE_LEN = 150;
    localparam int GAP_PCT = 13;

    class set_tracker;
        logic signed [ust_pkg::VALUE_W-1:0] slot_val [CAPACITY];
        int used;
        int failures;
        ust_pkg::out_item_t due_results [$];

        function new();
            used = 0;
            failures = 0;
        endfunction

        function void note_operation(ust_pkg::in_item_t op);
            ust_pkg::out_item_t res;
            int slot;
            logic hit;
            slot = used;
            hit = 1'b0;
            for (int i = 0; i < used; i++) begin
                if (!hit && slot_val[i] == op.item_value) begin
                    slot = i;
                    hit = 1'b1;
                end
            end
            res.found = hit;
            res.position = slot[ust_pkg::POS_W-1:0];
            res.status = ust_pkg::ST_DONE;
            case (op.action)
                ust_pkg::ACT_INSERT: begin
                    if (hit) begin
                        res.status = ust_pkg::ST_PRESENT;
                    end else if (used == CAPACITY) begin
                        res.status = ust_pkg::ST_FULL;
                    end else begin
                        slot_val[used] = op.item_value;
                        used++;
                    end
                end
                ust_pkg::ACT_DELETE: begin
                    if (hit) begin
                        slot_val[slot] = slot_val[used-1];
                        used--;
                    end else begin
                        res.status = ust_pkg::ST_ABSENT;
                    end
                end
                default: begin
                end
            endcase
            res.entry_count = used[ust_pkg::POS_W-1:0];
            due_results.push_back(res);
        endfunction

        function void check_result(ust_pkg::out_item_t got);
            ust_pkg::out_item_t want;
            if (due_results.size() == 0) begin
                $error("Result transaction arrived with no operation outstanding.");
                failures++;
                return;
            end
            want = due_results.pop_front();
            if (got.found !== want.found) begin
                $error("found: expected %0d, actual %0d", want.found, got.found);
                failures++;
            end
            if (got.position !== want.position) begin
                $error("position: expected %0d, actual %0d", want.position, got.position);
                failures++;
            end
            if (got.entry_count !== want.entry_count) begin
                $error("entry_count: expected %0d, actual %0d",
                       want.entry_count, got.entry_count);
                failures++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                failures++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    ust_pkg::in_item_t s_data;
    logic m_valid;
    logic m_ready;
    ust_pkg::out_item_t m_data;
    logic steady;
    set_tracker tracker;

    unordered_set_table #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = aresetn && (steady || ($urandom_range(99) >= GAP_PCT));
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_result(m_data);
        end
    end

    task automatic send_op(input logic [ust_pkg::ACTION_W-1:0] act,
                           input logic signed [ust_pkg::VALUE_W-1:0] val);
        ust_pkg::in_item_t op;
        op.action = act;
        op.item_value = val;
        while (!steady && $urandom_range(99) < GAP_PCT) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = op;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        tracker.note_operation(op);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic drain_results();
        while (tracker.due_results.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    function automatic logic signed [ust_pkg::VALUE_W-1:0] pick_value(int fresh_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < fresh_pct || tracker.used == 0) begin
            return $urandom;
        end else if (roll < fresh_pct + 10) begin
            case ($urandom_range(5))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return VAL_ZERO;
                3: return VAL_NEG1;
                4: return VAL_ALT0;
                default: return VAL_ALT1;
            endcase
        end
        return tracker.slot_val[$urandom_range(tracker.used - 1)];
    endfunction

    function automatic logic [ust_pkg::ACTION_W-1:0] pick_action(int ins_pct, int del_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < ins_pct) begin
            return ust_pkg::ACT_INSERT;
        end else if (roll < ins_pct + del_pct) begin
            return ust_pkg::ACT_DELETE;
        end else if (roll < 95) begin
            return ust_pkg::ACT_QUERY;
        end
        return ACT_SPARE;
    endfunction

    initial begin
        int mode;
        tracker = new();
        steady = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        send_op(ust_pkg::ACT_QUERY, VAL_ZERO);
        send_op(ust_pkg::ACT_DELETE, 32'sd5);
        send_op(ust_pkg::ACT_INSERT, VAL_MIN);
        send_op(ust_pkg::ACT_INSERT, VAL_MAX);
        send_op(ust_pkg::ACT_INSERT, VAL_ZERO);
        send_op(ust_pkg::ACT_INSERT, VAL_NEG1);
        send_op(ust_pkg::ACT_INSERT, VAL_MIN);
        send_op(ust_pkg::ACT_QUERY, VAL_MAX);
        send_op(ACT_SPARE, VAL_NEG1);
        send_op(ust_pkg::ACT_QUERY, 32'sd12345);
        send_op(ust_pkg::ACT_DELETE, VAL_NEG1);
        send_op(ust_pkg::ACT_DELETE, VAL_MIN);
        send_op(ust_pkg::ACT_DELETE, VAL_MIN);
        send_op(ACT_SPARE, 32'sd77);
        send_op(ust_pkg::ACT_INSERT, VAL_ALT0);
        send_op(ust_pkg::ACT_INSERT, VAL_ALT1);
        send_op(ust_pkg::ACT_DELETE, VAL_ZERO);
        send_op(ust_pkg::ACT_QUERY, VAL_ALT1);
        drain_results();

        for (int n = 0; n < RANDOM_OPS; n++) begin
            steady = (n >= 500 && n < 800);
            if (n == 800) begin
                drain_results();
            end
            mode = (n / PHASE_LEN) % 3;
            case (mode)
                0: send_op(pick_action(75, 10), pick_value(70));
                1: send_op(pick_action(35, 35), pick_value(30));
                default: send_op(pick_action(15, 70), pick_value(10));
            endcase
        end
        steady = 1'b0;

        drain_results();
        repeat (CAPACITY + 10) @(negedge aclk);
        if (tracker.failures == 0 && tracker.due_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
